/* rtl/core/gha_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants of the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

    localparam int SLOTS_DEF = 1024;
    localparam int OP_W      = 2;
    localparam int HANDLE_W  = 32;
    localparam int GEN_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 10;
    localparam int TOTAL_W   = 11;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_LOOKUP  = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_STALE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_ALLOC,
        S_CHECK,
        S_MOVE,
        S_FREE,
        S_FIN
    } t_state;

    typedef struct packed {
        t_status              status;
        logic [HANDLE_W-1:0]  handle;
        logic [POS_W-1:0]     pos;
        logic [POS_W-1:0]     from;
        logic                 moved;
    } t_result;

endpackage
`default_nettype wire

/* rtl/core/gha_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gha_ram
// One write port, one read port table with registered read data.
// ----------------------------------------------------------------------------
module gha_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/generational_handle_allocator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// Handle allocator with 16-bit slot generations over a densely packed array.
// Allocate pops the free-list head, release fills the dense hole with the
// last live entry and appends the slot to the free-list tail, lookup checks
// a handle and reports its dense position.
//
//   channel  direction  handshake                 payload
//   request  in         i_in_valid / o_in_ready   i_op, i_handle
//   result   out        o_out_valid / i_out_ready o_status, o_result_handle,
//                                                 o_dense_pos, o_moved_from,
//                                                 o_moved, o_live_total
//
// Allocate runs dispatch, alloc, fin; lookup dispatch, check, fin; release
// dispatch, check, move when an entry fills the hole, free, fin. A full
// allocate or an out-of-range slot ends after dispatch, a stale handle after
// check. Each table has one read and one write port, and the sequencer steps
// through the dependent table accesses. After reset a clearing pass
// initializes the generation, live and free-list tables; no request is taken
// meanwhile. A stalled result holds in the output register; the next request
// is taken meanwhile and waits in its last step until the output frees.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit #(
    parameter int SLOTS = gha_pkg::SLOTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [gha_pkg::OP_W-1:0]      i_op,
    input  wire logic [gha_pkg::HANDLE_W-1:0]  i_handle,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [gha_pkg::STATUS_W-1:0]  o_status,
    output logic      [gha_pkg::HANDLE_W-1:0]  o_result_handle,
    output logic      [gha_pkg::POS_W-1:0]     o_dense_pos,
    output logic      [gha_pkg::POS_W-1:0]     o_moved_from,
    output logic                               o_moved,
    output logic      [gha_pkg::TOTAL_W-1:0]   o_live_total
);

    import gha_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int RW = GEN_W + 1;

    t_state              r_state, n_state;
    logic [SW-1:0]       r_clr, n_clr;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_head, n_head;
    logic [SW-1:0]       r_tail, n_tail;
    t_op                 r_op, n_op;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic [SW-1:0]       r_hole, n_hole;
    logic [SW-1:0]       r_last, n_last;
    logic                r_was_full, n_was_full;
    t_result             r_res, n_res;

    logic                r_out_valid;
    t_result             r_out;
    logic [CW-1:0]       r_out_total;

    logic                w_slot_we;
    logic [SW-1:0]       w_slot_waddr, w_slot_raddr;
    logic [RW-1:0]       w_slot_wdata, w_slot_rdata;
    logic                w_sdi_we;
    logic [SW-1:0]       w_sdi_waddr, w_sdi_raddr, w_sdi_wdata, w_sdi_rdata;
    logic                w_next_we;
    logic [SW-1:0]       w_next_waddr, w_next_raddr;
    logic [CW-1:0]       w_next_wdata, w_next_rdata;
    logic                w_own_we;
    logic [SW-1:0]       w_own_waddr, w_own_raddr, w_own_wdata, w_own_rdata;

    logic                w_in_acc;
    logic                w_fin_load;
    logic [SW-1:0]       w_hslot;
    logic                w_in_range;
    logic                w_live;
    logic [GEN_W-1:0]    w_gen_new;

    gha_ram #(.DEPTH(SLOTS), .WIDTH(RW)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_waddr),
        .i_wdata (w_slot_wdata),
        .i_raddr (w_slot_raddr),
        .o_rdata (w_slot_rdata)
    );

    gha_ram #(.DEPTH(SLOTS), .WIDTH(SW)) u_sdi_ram (
        .i_clk   (i_clk),
        .i_we    (w_sdi_we),
        .i_waddr (w_sdi_waddr),
        .i_wdata (w_sdi_wdata),
        .i_raddr (w_sdi_raddr),
        .o_rdata (w_sdi_rdata)
    );

    gha_ram #(.DEPTH(SLOTS), .WIDTH(CW)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_next_we),
        .i_waddr (w_next_waddr),
        .i_wdata (w_next_wdata),
        .i_raddr (w_next_raddr),
        .o_rdata (w_next_rdata)
    );

    gha_ram #(.DEPTH(SLOTS), .WIDTH(SW)) u_own_ram (
        .i_clk   (i_clk),
        .i_we    (w_own_we),
        .i_waddr (w_own_waddr),
        .i_wdata (w_own_wdata),
        .i_raddr (w_own_raddr),
        .o_rdata (w_own_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_hslot    = r_handle[SW-1:0];
    assign w_in_range = {1'b0, r_handle[15:0]} < 17'(SLOTS);
    assign w_live     = w_slot_rdata[GEN_W]
                        && (w_slot_rdata[GEN_W-1:0] == r_handle[HANDLE_W-1:GEN_W]);
    assign w_gen_new  = w_slot_rdata[GEN_W-1:0] + GEN_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= SW'(SLOTS - 1);
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_handle   <= n_handle;
        r_hole     <= n_hole;
        r_last     <= n_last;
        r_was_full <= n_was_full;
        r_res      <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_count    = r_count;
        n_head     = r_head;
        n_tail     = r_tail;
        n_op       = r_op;
        n_handle   = r_handle;
        n_hole     = r_hole;
        n_last     = r_last;
        n_was_full = r_was_full;
        n_res      = r_res;
        w_fin_load = 1'b0;

        w_slot_we    = 1'b0;
        w_slot_waddr = '0;
        w_slot_wdata = '0;
        w_slot_raddr = '0;
        w_sdi_we     = 1'b0;
        w_sdi_waddr  = '0;
        w_sdi_wdata  = '0;
        w_sdi_raddr  = '0;
        w_next_we    = 1'b0;
        w_next_waddr = '0;
        w_next_wdata = '0;
        w_next_raddr = '0;
        w_own_we     = 1'b0;
        w_own_waddr  = '0;
        w_own_wdata  = '0;
        w_own_raddr  = '0;

        case (r_state)
            S_CLEAR: begin
                w_slot_we    = 1'b1;
                w_slot_waddr = r_clr;
                w_next_we    = 1'b1;
                w_next_waddr = r_clr;
                w_next_wdata = CW'(r_clr) + CW'(1);
                if (r_clr == SW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + SW'(1);
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_op)
                        OP_ALLOC:   n_op = OP_ALLOC;
                        OP_RELEASE: n_op = OP_RELEASE;
                        default:    n_op = OP_LOOKUP;
                    endcase
                    n_handle = i_handle;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res.status = ST_OK;
                n_res.handle = r_handle;
                n_res.pos    = '0;
                n_res.from   = '0;
                n_res.moved  = 1'b0;
                case (r_op)
                    OP_ALLOC: begin
                        n_res.handle = '0;
                        if (r_count >= CW'(SLOTS) || r_head >= CW'(SLOTS)) begin
                            n_res.status = ST_FULL;
                            n_state      = S_FIN;
                        end else begin
                            w_slot_raddr = r_head[SW-1:0];
                            w_next_raddr = r_head[SW-1:0];
                            n_state      = S_ALLOC;
                        end
                    end
                    default: begin
                        if (!w_in_range) begin
                            n_res.status = ST_STALE;
                            n_state      = S_FIN;
                        end else begin
                            w_slot_raddr = w_hslot;
                            w_sdi_raddr  = w_hslot;
                            n_state      = S_CHECK;
                        end
                    end
                endcase
            end
            S_ALLOC: begin
                w_slot_we    = 1'b1;
                w_slot_waddr = r_head[SW-1:0];
                w_slot_wdata = {1'b1, w_gen_new};
                w_sdi_we     = 1'b1;
                w_sdi_waddr  = r_head[SW-1:0];
                w_sdi_wdata  = r_count[SW-1:0];
                w_own_we     = 1'b1;
                w_own_waddr  = r_count[SW-1:0];
                w_own_wdata  = r_head[SW-1:0];
                n_head       = w_next_rdata;
                n_count      = r_count + CW'(1);
                n_res.handle = {w_gen_new, 16'(r_head)};
                n_res.pos    = POS_W'(r_count);
                n_state      = S_FIN;
            end
            S_CHECK: begin
                if (!w_live || (r_op == OP_RELEASE && r_count == '0)) begin
                    n_res.status = ST_STALE;
                    n_state      = S_FIN;
                end else if (r_op != OP_RELEASE) begin
                    n_res.pos = POS_W'(w_sdi_rdata);
                    n_state   = S_FIN;
                end else begin
                    w_slot_we    = 1'b1;
                    w_slot_waddr = w_hslot;
                    w_slot_wdata = {1'b0, w_slot_rdata[GEN_W-1:0]};
                    n_hole       = w_sdi_rdata;
                    n_last       = SW'(r_count - CW'(1));
                    n_was_full   = (r_count == CW'(SLOTS));
                    n_count      = r_count - CW'(1);
                    n_res.pos    = POS_W'(w_sdi_rdata);
                    w_own_raddr  = n_last;
                    if (w_sdi_rdata != n_last) begin
                        n_state = S_MOVE;
                    end else begin
                        n_state = S_FREE;
                    end
                end
            end
            S_MOVE: begin
                w_own_we    = 1'b1;
                w_own_waddr = r_hole;
                w_own_wdata = w_own_rdata;
                w_sdi_we    = 1'b1;
                w_sdi_waddr = w_own_rdata;
                w_sdi_wdata = r_hole;
                n_res.moved = 1'b1;
                n_res.from  = POS_W'(r_last);
                n_state     = S_FREE;
            end
            S_FREE: begin
                w_next_we    = 1'b1;
                w_next_waddr = r_tail;
                w_next_wdata = CW'(w_hslot);
                n_tail       = w_hslot;
                if (r_was_full) begin
                    n_head = CW'(w_hslot);
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    w_fin_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_load) begin
            r_out       <= r_res;
            r_out_total <= r_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_result_handle = r_out.handle;
    assign o_dense_pos     = r_out.pos;
    assign o_moved_from    = r_out.from;
    assign o_moved         = r_out.moved;
    assign o_live_total    = TOTAL_W'(r_out_total);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("live count above slot total");

    a_free_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE && r_count < CW'(SLOTS) |-> r_head < CW'(SLOTS))
        else $error("free list empty below full count");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("request taken while busy");

    a_moved_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_moved |-> o_status == ST_OK && o_dense_pos != o_moved_from)
        else $error("move reported on a failed or degenerate release");

    a_rise_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result raised outside the final step");

endmodule
`default_nettype wire

/* tb/sv/generational_handle_allocator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit_tb
// Sends allocate, release and lookup requests with random gaps and result
// stalls. It keeps its own slot, dense and free-list tables, updates them on
// every accepted request, and compares each result field by field.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit_tb;
    import gha_pkg::*;

    localparam int SLOTS = SLOTS_DEF;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [HANDLE_W-1:0] handle;
    } handle_req_t;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] handle;
        logic [POS_W-1:0]    pos;
        logic [POS_W-1:0]    src_pos;
        logic                moved;
        logic [TOTAL_W-1:0]  total;
    } handle_reply_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic [OP_W-1:0]     i_op = '0;
    logic [HANDLE_W-1:0] i_handle = '0;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [HANDLE_W-1:0] o_result_handle;
    logic [POS_W-1:0]    o_dense_pos;
    logic [POS_W-1:0]    o_moved_from;
    logic                o_moved;
    logic [TOTAL_W-1:0]  o_live_total;

    logic [GEN_W-1:0]    gen_tbl [SLOTS];
    logic [POS_W-1:0]    dense_tbl [SLOTS];
    logic                live_tbl [SLOTS];
    logic [TOTAL_W-1:0]  next_free_tbl [SLOTS];
    logic [POS_W-1:0]    owner_tbl [SLOTS];
    logic [TOTAL_W-1:0]  live_count;
    logic [TOTAL_W-1:0]  free_head;
    logic [POS_W-1:0]    free_tail;

    handle_req_t   op_q[$];
    handle_reply_t reply_q[$];
    int gap_left = 0;
    int stall_left = 0;
    int idle_cnt = 0;
    int err_count = 0;
    bit idle_on = 1'b1;

    generational_handle_allocator_unit #(
        .SLOTS(SLOTS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_op(i_op),
        .i_handle(i_handle),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_result_handle(o_result_handle),
        .o_dense_pos(o_dense_pos),
        .o_moved_from(o_moved_from),
        .o_moved(o_moved),
        .o_live_total(o_live_total)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic handle_reply_t step_handle_table(input logic [OP_W-1:0] op,
                                                        input logic [HANDLE_W-1:0] handle);
        handle_reply_t r;
        int s;
        int hole;
        int last;
        int mover;
        logic hit;
        logic was_full;
        r.status = ST_OK;
        r.handle = handle;
        r.pos = '0;
        r.src_pos = '0;
        r.moved = 1'b0;
        s = int'(handle[GEN_W-1:0]);
        hit = 1'b0;
        if (s < SLOTS) begin
            hit = live_tbl[s] && (gen_tbl[s] == handle[HANDLE_W-1:GEN_W]);
        end
        if (op == OP_ALLOC) begin
            r.handle = '0;
            if (live_count >= SLOTS || free_head >= SLOTS) begin
                r.status = ST_FULL;
            end else begin
                s = int'(free_head);
                free_head = next_free_tbl[s];
                gen_tbl[s] = gen_tbl[s] + 1'b1;
                dense_tbl[s] = live_count[POS_W-1:0];
                owner_tbl[int'(live_count)] = s[POS_W-1:0];
                live_tbl[s] = 1'b1;
                r.pos = live_count[POS_W-1:0];
                live_count = live_count + 1'b1;
                r.handle = {gen_tbl[s], s[GEN_W-1:0]};
            end
        end else if (op == OP_RELEASE) begin
            if (!hit || live_count == 0) begin
                r.status = ST_STALE;
            end else begin
                hole = int'(dense_tbl[s]);
                last = int'(live_count) - 1;
                was_full = (live_count >= SLOTS);
                if (hole != last) begin
                    mover = int'(owner_tbl[last]);
                    owner_tbl[hole] = mover[POS_W-1:0];
                    dense_tbl[mover] = hole[POS_W-1:0];
                    r.moved = 1'b1;
                    r.src_pos = last[POS_W-1:0];
                end
                live_count = live_count - 1'b1;
                live_tbl[s] = 1'b0;
                r.pos = hole[POS_W-1:0];
                next_free_tbl[int'(free_tail)] = s[TOTAL_W-1:0];
                free_tail = s[POS_W-1:0];
                if (was_full) begin
                    free_head = s[TOTAL_W-1:0];
                end
            end
        end else if (!hit) begin
            r.status = ST_STALE;
        end else begin
            r.pos = dense_tbl[s];
        end
        r.total = live_count;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [HANDLE_W-1:0] live_handle(input int p);
        int s;
        s = int'(owner_tbl[p]);
        return {gen_tbl[s], s[GEN_W-1:0]};
    endfunction

    function automatic logic [HANDLE_W-1:0] any_live_handle();
        if (live_count == 0) return $urandom();
        return live_handle($urandom_range(0, int'(live_count) - 1));
    endfunction

    function automatic logic [HANDLE_W-1:0] noisy_handle();
        logic [HANDLE_W-1:0] h;
        int b;
        h = $urandom();
        b = $urandom_range(0, GEN_W - 1);
        case ($urandom_range(0, 3))
            0: h = h;
            1: h[GEN_W-1:0] = GEN_W'($urandom_range(0, SLOTS - 1));
            2: begin
                if (live_count != 0) begin
                    h = any_live_handle();
                    h[GEN_W + b] = ~h[GEN_W + b];
                end
            end
            default: begin
                if (live_count != 0) begin
                    h = any_live_handle();
                    h[b] = ~h[b];
                end
            end
        endcase
        return h;
    endfunction

    task automatic send(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] handle);
        handle_req_t req;
        req.op = op;
        req.handle = handle;
        while (op_q.size() >= 2) @(negedge i_clk);
        op_q.push_back(req);
    endtask

    task automatic settle();
        @(negedge i_clk);
        while (op_q.size() != 0 || i_in_valid || reply_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic issue_random(input int w_alloc, input int w_release);
        int pick;
        logic [HANDLE_W-1:0] h;
        pick = $urandom_range(0, 99);
        h = ($urandom_range(0, 9) == 0) ? noisy_handle() : any_live_handle();
        if (pick < w_alloc) begin
            send(OP_ALLOC, $urandom());
        end else if (pick < w_alloc + w_release) begin
            send(OP_RELEASE, h);
            if ($urandom_range(0, 19) == 0) send(OP_RELEASE, h);
        end else begin
            send(($urandom_range(0, 7) == 0) ? OP_SPARE : OP_LOOKUP, h);
        end
    endtask

    task automatic check_field(input string name, input logic [HANDLE_W-1:0] want,
                               input logic [HANDLE_W-1:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        handle_req_t req;
        if (i_in_valid && o_in_ready) begin
            reply_q.push_back(step_handle_table(i_op, i_handle));
        end
        if (!i_in_valid || o_in_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (i_rst_n && op_q.size() != 0) begin
                req = op_q.pop_front();
                i_op <= req.op;
                i_handle <= req.handle;
                i_in_valid <= 1'b1;
                gap_left = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        handle_reply_t want;
        if (o_out_valid && i_out_ready) begin
            if (reply_q.size() == 0) begin
                err_count++;
                $display("%0t: result with no request pending, status %0d handle %h",
                         $time, o_status, o_result_handle);
            end else begin
                want = reply_q.pop_front();
                check_field("status", HANDLE_W'(want.status), HANDLE_W'(o_status));
                check_field("result_handle", want.handle, o_result_handle);
                check_field("dense_pos", HANDLE_W'(want.pos), HANDLE_W'(o_dense_pos));
                check_field("moved_from", HANDLE_W'(want.src_pos),
                            HANDLE_W'(o_moved_from));
                check_field("moved", HANDLE_W'(want.moved), HANDLE_W'(o_moved));
                check_field("live_total", HANDLE_W'(want.total),
                            HANDLE_W'(o_live_total));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cnt = 0;
        end else begin
            idle_cnt++;
            if (idle_cnt >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        logic [HANDLE_W-1:0] h;
        for (int i = 0; i < SLOTS; i++) begin
            gen_tbl[i] = '0;
            dense_tbl[i] = '0;
            live_tbl[i] = 1'b0;
            owner_tbl[i] = '0;
            next_free_tbl[i] = TOTAL_W'(i + 1);
        end
        live_count = '0;
        free_head = '0;
        free_tail = POS_W'(SLOTS - 1);

        send(OP_ALLOC, '0);
        send(OP_ALLOC, '1);
        send(OP_ALLOC, $urandom());
        send(OP_ALLOC, 32'h8000_0001);
        // hold until the table has answered everything
        settle();
        send(OP_LOOKUP, live_handle(0));
        send(OP_LOOKUP, '0);
        send(OP_LOOKUP, '1);
        send(OP_LOOKUP, {16'd1, 16'd5});
        send(OP_SPARE, live_handle(2));
        send(OP_SPARE, '1);
        h = live_handle(1);
        send(OP_RELEASE, h);
        send(OP_RELEASE, h);
        send(OP_LOOKUP, h);
        settle();
        send(OP_RELEASE, live_handle(int'(live_count) - 1));
        settle();
        send(OP_RELEASE, live_handle(1));
        send(OP_RELEASE, live_handle(0));
        settle();
        send(OP_RELEASE, h);
        send(OP_ALLOC, '0);
        send(OP_ALLOC, '1);

        repeat (150) issue_random(40, 25);
        while (live_count < SLOTS) issue_random(92, 3);
        repeat (40) issue_random(35, 40);
        idle_on = 1'b0;
        repeat (200) issue_random(10, 75);
        idle_on = 1'b1;
        repeat (200) issue_random(40, 30);

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && reply_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
